// ----- rtl/core/sv39ptw_pkg.sv -----
// Shared types and constants of the Sv39 page table walker.
`timescale 1ns / 1ps
package sv39ptw_pkg;

  // Size of the table frame pool.
  localparam int unsigned NUM_FRAMES        = 16;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned FRAME_W           = $clog2(NUM_FRAMES);
  localparam int unsigned FCNT_W            = $clog2(NUM_FRAMES + 1);
  localparam int unsigned STORE_DEPTH       = NUM_FRAMES * ENTRIES_PER_TABLE;
  localparam int unsigned ADDR_W            = FRAME_W + IDX_W;

  // Field widths.
  localparam int unsigned PTE_W      = 64;
  localparam int unsigned PPN_W      = 44;
  localparam int unsigned VPN_W      = 27;
  localparam int unsigned PADDR_W    = 56;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PERM_W     = 3;

  // Page table entry layout.
  localparam int unsigned PTE_V       = 0;
  localparam int unsigned PTE_R       = 1;
  localparam int unsigned PTE_W_BIT   = 2;
  localparam int unsigned PTE_X       = 3;
  localparam int unsigned PTE_U       = 4;
  localparam int unsigned PTE_PPN_LSB = 10;
  localparam int unsigned PTE_PPN_MSB = PTE_PPN_LSB + PPN_W - 1;

  // Permission bits of a map request.
  localparam int unsigned PERM_WRITE = 0;
  localparam int unsigned PERM_EXEC  = 1;
  localparam int unsigned PERM_USER  = 2;

  // Walk levels.
  localparam logic [1:0] LVL_ROOT = 2'd0;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_LEAF = 2'd2;

  // Request commands.
  localparam logic CMD_MAP    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned REG_IDX_LSB = 3;
  localparam logic [CFG_ADDR_W-REG_IDX_LSB-1:0] REG_POOL_BASE_PPN = '0;

  typedef struct packed {
    logic               cmd;
    logic [VPN_W-1:0]   virt_page;
    logic [PPN_W-1:0]   phys_page;
    logic [PERM_W-1:0]  perm_flags;
  } req_t;

  typedef struct packed {
    logic [PADDR_W-1:0] phys_addr;
    logic               found;
    logic               out_of_frames;
  } rsp_t;

  // One access of the table store.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [PTE_W-1:0]  wdata;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ZERO,
    ST_LINK,
    ST_LEAF,
    ST_DONE
  } walk_state_e;

endpackage

// ----- rtl/core/sv39ptw_cfg.sv -----
// APB register holding the physical page number of the frame pool base.
`timescale 1ns / 1ps
module sv39ptw_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sv39ptw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sv39ptw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sv39ptw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                pready,
  output logic [sv39ptw_pkg::PPN_W-1:0]       pool_base_ppn_o
);
  import sv39ptw_pkg::*;

  logic [PPN_W-1:0]                     pool_base_q;
  logic [CFG_ADDR_W-REG_IDX_LSB-1:0]    reg_idx;
  logic                                 hit;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:REG_IDX_LSB];
  assign hit     = (reg_idx == REG_POOL_BASE_PPN);

  // The register is written in the access phase of a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (psel && penable && pwrite && hit) begin
      pool_base_q <= pwdata[PPN_W-1:0];
    end
  end

  // Reads return the register zero-extended, or zero outside the map.
  assign prdata = hit ? CFG_DATA_W'(pool_base_q) : '0;

  assign pool_base_ppn_o = pool_base_q;

endmodule

// ----- rtl/core/sv39ptw_table_ram.sv -----
// Single-port synchronous store of all page table frames.
`timescale 1ns / 1ps
module sv39ptw_table_ram (
  input  logic                         clk_i,
  input  sv39ptw_pkg::ram_req_t        ram_req_i,
  output logic [sv39ptw_pkg::PTE_W-1:0] rdata_o
);
  import sv39ptw_pkg::*;

  logic [PTE_W-1:0] mem [STORE_DEPTH];
  logic [PTE_W-1:0] rdata_q;

  // One write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (ram_req_i.wr_en) begin
      mem[ram_req_i.addr] <= ram_req_i.wdata;
    end
    if (ram_req_i.rd_en) begin
      rdata_q <= mem[ram_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/sv39ptw_walker.sv -----
// Walk sequencer: clears the store, walks three levels, allocates and zeroes frames.
`timescale 1ns / 1ps
module sv39ptw_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sv39ptw_pkg::req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sv39ptw_pkg::rsp_t             out_rsp_o,
  input  logic [sv39ptw_pkg::PPN_W-1:0] pool_base_ppn_i,
  output sv39ptw_pkg::ram_req_t         ram_req_o,
  input  logic [sv39ptw_pkg::PTE_W-1:0] ram_rdata_i
);
  import sv39ptw_pkg::*;

  walk_state_e          state_q, state_d;
  logic [1:0]           lvl_q, lvl_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic [FRAME_W-1:0]   alloc_q, alloc_d;
  logic [FCNT_W-1:0]    next_free_q, next_free_d;
  logic [ADDR_W-1:0]    sweep_q, sweep_d;
  req_t                 req_q, req_d;
  rsp_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_rsp_q, out_rsp_d;

  logic [IDX_W-1:0]     cur_idx;
  logic [ADDR_W-1:0]    walk_addr;
  logic [PPN_W-1:0]     ptr_off;
  logic                 ptr_ok;
  logic [PPN_W-1:0]     link_ppn;
  logic [PTE_W-1:0]     link_pte;
  logic [PTE_W-1:0]     leaf_pte;

  // Index of the current level taken from the virtual page number.
  always_comb begin
    unique case (lvl_q)
      LVL_ROOT: cur_idx = req_q.virt_page[3*IDX_W-1:2*IDX_W];
      LVL_MID:  cur_idx = req_q.virt_page[2*IDX_W-1:IDX_W];
      default:  cur_idx = req_q.virt_page[IDX_W-1:0];
    endcase
  end

  assign walk_addr = {frame_q, cur_idx};

  // A pointer entry is usable when valid and its frame lies inside the pool.
  assign ptr_off = ram_rdata_i[PTE_PPN_MSB:PTE_PPN_LSB] - pool_base_ppn_i;
  assign ptr_ok  = ram_rdata_i[PTE_V] && (ptr_off < PPN_W'(NUM_FRAMES));

  // Pointer entry that links a freshly allocated frame.
  assign link_ppn = pool_base_ppn_i + PPN_W'(alloc_q);
  always_comb begin
    link_pte = '0;
    link_pte[PTE_PPN_MSB:PTE_PPN_LSB] = link_ppn;
    link_pte[PTE_V] = 1'b1;
  end

  // Leaf entry of a map request.
  always_comb begin
    leaf_pte = '0;
    leaf_pte[PTE_PPN_MSB:PTE_PPN_LSB] = req_q.phys_page;
    leaf_pte[PTE_V]     = 1'b1;
    leaf_pte[PTE_R]     = 1'b1;
    leaf_pte[PTE_W_BIT] = req_q.perm_flags[PERM_WRITE];
    leaf_pte[PTE_X]     = req_q.perm_flags[PERM_EXEC];
    leaf_pte[PTE_U]     = req_q.perm_flags[PERM_USER];
  end

  // Next state and store accesses.
  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    frame_d     = frame_q;
    alloc_d     = alloc_q;
    next_free_d = next_free_q;
    sweep_d     = sweep_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    ram_req_o       = '0;
    ram_req_o.addr  = walk_addr;
    in_stall_o  = (state_q != ST_IDLE);

    unique case (state_q)
      ST_CLEAR: begin
        ram_req_o.wr_en = 1'b1;
        ram_req_o.addr  = sweep_q;
        if (sweep_q == ADDR_W'(STORE_DEPTH - 1)) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          lvl_d   = LVL_ROOT;
          frame_d = '0;
          res_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (lvl_q == LVL_LEAF && req_q.cmd == CMD_MAP) begin
          state_d = ST_LEAF;
        end else begin
          ram_req_o.rd_en = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (lvl_q != LVL_LEAF) begin
          if (ptr_ok) begin
            frame_d = ptr_off[FRAME_W-1:0];
            lvl_d   = lvl_q + 1'b1;
            state_d = ST_READ;
          end else if (req_q.cmd == CMD_LOOKUP) begin
            state_d = ST_DONE;
          end else if (next_free_q >= FCNT_W'(NUM_FRAMES)) begin
            res_d.out_of_frames = 1'b1;
            state_d = ST_DONE;
          end else begin
            alloc_d     = next_free_q[FRAME_W-1:0];
            next_free_d = next_free_q + 1'b1;
            sweep_d     = '0;
            state_d     = ST_ZERO;
          end
        end else begin
          if (ram_rdata_i[PTE_V]) begin
            res_d.phys_addr = {ram_rdata_i[PTE_PPN_MSB:PTE_PPN_LSB], PAGE_SHIFT'(0)};
            res_d.found     = 1'b1;
          end
          state_d = ST_DONE;
        end
      end
      ST_ZERO: begin
        ram_req_o.wr_en = 1'b1;
        ram_req_o.addr  = {alloc_q, sweep_q[IDX_W-1:0]};
        if (sweep_q[IDX_W-1:0] == IDX_W'(ENTRIES_PER_TABLE - 1)) begin
          sweep_d = '0;
          state_d = ST_LINK;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_LINK: begin
        ram_req_o.wr_en = 1'b1;
        ram_req_o.wdata = link_pte;
        frame_d = alloc_q;
        lvl_d   = lvl_q + 1'b1;
        state_d = ST_READ;
      end
      ST_LEAF: begin
        ram_req_o.wr_en = 1'b1;
        ram_req_o.wdata = leaf_pte;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      lvl_q       <= LVL_ROOT;
      next_free_q <= FCNT_W'(1);
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      next_free_q <= next_free_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    frame_q   <= frame_d;
    alloc_q   <= alloc_d;
    req_q     <= req_d;
    res_q     <= res_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- rtl/core/sv39_page_table_walker_unit.sv -----
// Top level of the Sv39 page table walker with its local frame pool.
`timescale 1ns / 1ps
// Usage:
//   A request on the in channel (in_valid_i, in_stall_o, in_req_i) either maps one
//   virtual page (cmd 0) or looks one up (cmd 1). Each request gives exactly one
//   response on the out channel (out_valid_o, out_stall_i, out_rsp_o).
//   Requests are handled one at a time; each walks the table levels with a read and
//   an evaluate state per level in the single-port table store (a map writes its
//   leaf in the leaf state instead of reading it), so the walk sets the rate.
//   Each newly allocated table is first zeroed, one entry a cycle, and then linked
//   into its parent entry.
//   The next request is taken in the cycle after the response register is loaded,
//   even if the receiver still stalls the previous response. While the response
//   register is full and stalled, a finished walk waits before loading it.
//   After reset the table store is cleared, all NUM_FRAMES * 512 entries (8192
//   entries), with in_stall_o high; frame zero is then the empty root and frame one
//   is the next free frame. The APB register pool_base_ppn (byte address 0) may be
//   written at any time the walker is idle.
module sv39_page_table_walker_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sv39ptw_pkg::req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sv39ptw_pkg::rsp_t                   out_rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sv39ptw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sv39ptw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sv39ptw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                pready
);
  import sv39ptw_pkg::*;

  logic [PPN_W-1:0] pool_base_ppn;
  ram_req_t         ram_req;
  logic [PTE_W-1:0] ram_rdata;

  // Configuration register.
  sv39ptw_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .pool_base_ppn_o (pool_base_ppn)
  );

  // Walk sequencer.
  sv39ptw_walker u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_req_i        (in_req_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_rsp_o       (out_rsp_o),
    .pool_base_ppn_i (pool_base_ppn),
    .ram_req_o       (ram_req),
    .ram_rdata_i     (ram_rdata)
  );

  // Table store.
  sv39ptw_table_ram u_table_ram (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rdata_o   (ram_rdata)
  );

endmodule
